// ===== rtl/ctpl_pkg.sv =====
`timescale 1ns / 1ps

package ctpl_pkg;

  typedef enum logic [1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_REVERT  = 2'd1,
    MODE_LOAD    = 2'd2
  } mode_t;

  localparam logic [2:0] REG_GAIN_ALPHA = 3'd0;
  localparam logic [2:0] REG_GAIN_BETA  = 3'd1;
  localparam logic [2:0] REG_PERIOD_HI  = 3'd2;
  localparam logic [2:0] REG_PERIOD_LO  = 3'd3;
  localparam logic [2:0] REG_NOM_PERIOD = 3'd4;

  typedef struct packed {
    logic signed [24:0] gain_alpha;
    logic signed [24:0] gain_beta;
    logic [23:0]        period_hi;
    logic [23:0]        period_lo;
    logic [23:0]        nom_used;
  } cfg_t;

  // Fall back to the min/max midpoint when nominal lies outside the clamp range.
  function automatic logic [23:0] nom_pick(input logic [23:0] nom,
                                           input logic [23:0] mn,
                                           input logic [23:0] mx);
    logic [24:0] sum;
    sum = {1'b0, mn} + {1'b0, mx};
    if (nom < mn || nom > mx) begin
      return sum[24:1];
    end
    return nom;
  endfunction

endpackage

// ===== rtl/ctpl_cfg.sv =====
`timescale 1ns / 1ps

module ctpl_cfg #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ctpl_pkg::cfg_t      cfg
);
  import ctpl_pkg::*;

  localparam logic [23:0] RST_MAX = 24'(3 << FRAC_BITS);
  localparam logic [23:0] RST_MIN = 24'(1 << FRAC_BITS);
  localparam logic [23:0] RST_NOM = 24'(2 << FRAC_BITS);

  logic signed [24:0] gain_alpha;
  logic signed [24:0] gain_beta;
  logic [23:0]        period_hi;
  logic [23:0]        period_lo;
  logic [23:0]        nom_period;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_alpha <= '0;
      gain_beta  <= '0;
      period_hi  <= RST_MAX;
      period_lo  <= RST_MIN;
      nom_period <= RST_NOM;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_ALPHA: gain_alpha <= pwdata[24:0];
        REG_GAIN_BETA:  gain_beta  <= pwdata[24:0];
        REG_PERIOD_HI:  period_hi  <= pwdata[23:0];
        REG_PERIOD_LO:  period_lo  <= pwdata[23:0];
        REG_NOM_PERIOD: nom_period <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_ALPHA: prdata = 32'(gain_alpha);
      REG_GAIN_BETA:  prdata = 32'(gain_beta);
      REG_PERIOD_HI:  prdata = {8'd0, period_hi};
      REG_PERIOD_LO:  prdata = {8'd0, period_lo};
      REG_NOM_PERIOD: prdata = {8'd0, nom_period};
      default:        prdata = '0;
    endcase
  end

  assign cfg.gain_alpha = gain_alpha;
  assign cfg.gain_beta  = gain_beta;
  assign cfg.period_hi  = period_hi;
  assign cfg.period_lo  = period_lo;
  assign cfg.nom_used   = nom_pick(nom_period, period_lo, period_hi);

endmodule

// ===== rtl/ctpl_gain.sv =====
`timescale 1ns / 1ps

module ctpl_gain #(
  parameter int FRAC_BITS = 16,
  localparam int GAIN_FRAC = FRAC_BITS + 4,
  localparam int GM_W      = 44 - GAIN_FRAC
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctpl_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic signed [17:0]      in_err,
  input  logic signed [24:0]      in_pload,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_mode,
  output logic signed [24:0]      out_pload,
  output logic signed [GM_W-1:0]  out_pb,
  output logic signed [GM_W:0]    out_pab
);
  import ctpl_pkg::*;

  localparam logic signed [43:0] RND = 44'sd1 <<< (GAIN_FRAC - 1);

  logic               a_valid;
  logic [1:0]         a_mode;
  logic signed [17:0] a_err;
  logic signed [24:0] a_pload;
  logic               a_adv;
  logic               b_adv;
  logic signed [42:0] prod_a;
  logic signed [42:0] prod_b;
  logic signed [43:0] rnd_a;
  logic signed [43:0] rnd_b;
  logic signed [GM_W-1:0] pa;
  logic signed [GM_W-1:0] pb;

  assign b_adv    = !out_valid || out_ready;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_mode  <= in_mode;
      a_err   <= in_err;
      a_pload <= in_pload;
    end
  end

  // Gain products, rounded to nearest with ties up
  assign prod_a = cfg.gain_alpha * a_err;
  assign prod_b = cfg.gain_beta * a_err;
  assign rnd_a  = 44'(prod_a) + RND;
  assign rnd_b  = 44'(prod_b) + RND;
  assign pa     = rnd_a[43:GAIN_FRAC];
  assign pb     = rnd_b[43:GAIN_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      out_mode  <= a_mode;
      out_pload <= a_pload;
      out_pb    <= pb;
      out_pab   <= (GM_W + 1)'(pa) + (GM_W + 1)'(pb);
    end
  end

endmodule

// ===== rtl/ctpl_core.sv =====
`timescale 1ns / 1ps

module ctpl_core #(
  parameter int FRAC_BITS = 16,
  localparam int GAIN_FRAC = FRAC_BITS + 4,
  localparam int GM_W      = 44 - GAIN_FRAC
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctpl_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic signed [24:0]      in_pload,
  input  logic signed [GM_W-1:0]  in_pb,
  input  logic signed [GM_W:0]    in_pab,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             out_avg,
  output logic signed [24:0]      out_inst,
  output logic signed [24:0]      out_phase
);
  import ctpl_pkg::*;

  localparam int WW = ((GM_W + 1 > 25) ? GM_W + 1 : 25) + 6;
  localparam logic [23:0] RST_AVG =
    nom_pick(24'(2 << FRAC_BITS), 24'(1 << FRAC_BITS), 24'(3 << FRAC_BITS));
  localparam logic signed [WW-1:0] S25_MAX = (WW'(1) <<< 24) - WW'(1);
  localparam logic signed [WW-1:0] S25_MIN = -(WW'(1) <<< 24);

  logic [23:0]        avg_now;
  logic signed [24:0] inst_now;
  logic signed [24:0] phase_now;
  logic [23:0]        avg_before;
  logic signed [24:0] inst_before;
  logic signed [24:0] phase_before;

  logic [23:0]        avg_next;
  logic signed [24:0] inst_next;
  logic signed [24:0] phase_next;
  logic [23:0]        avg_before_next;
  logic signed [24:0] inst_before_next;
  logic signed [24:0] phase_before_next;

  logic signed [WW-1:0] avg_w;
  logic signed [WW-1:0] inst_w;
  logic signed [WW-1:0] inst_s;
  logic signed [WW-1:0] ph_w;
  logic signed [WW-1:0] max_w;
  logic signed [WW-1:0] min_w;
  logic [23:0]          avg_c;
  logic signed [24:0]   ph_s;
  logic                 take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Advance datapath
  always_comb begin
    avg_w  = WW'(avg_now) + WW'(in_pb);
    inst_w = WW'(avg_now) + WW'(in_pab);
    if (inst_w > S25_MAX) begin
      inst_s = S25_MAX;
    end else if (inst_w < S25_MIN) begin
      inst_s = S25_MIN;
    end else begin
      inst_s = inst_w;
    end
    ph_w = WW'(phase_now) + inst_s;
    // Two wrap passes against the unclamped average
    for (int k = 0; k < 2; k++) begin
      if ((ph_w <<< 1) > avg_w) begin
        ph_w = ph_w - avg_w;
      end else if ((ph_w <<< 1) <= -avg_w) begin
        ph_w = ph_w + avg_w;
      end
    end
    if (ph_w > S25_MAX) begin
      ph_s = S25_MAX[24:0];
    end else if (ph_w < S25_MIN) begin
      ph_s = S25_MIN[24:0];
    end else begin
      ph_s = ph_w[24:0];
    end
    max_w = WW'(cfg.period_hi);
    min_w = WW'(cfg.period_lo);
    if (avg_w > max_w) begin
      avg_c = cfg.period_hi;
    end else if (avg_w < min_w) begin
      avg_c = cfg.period_lo;
    end else begin
      avg_c = avg_w[23:0];
    end
  end

  always_comb begin
    avg_next          = avg_now;
    inst_next         = inst_now;
    phase_next        = phase_now;
    avg_before_next   = avg_before;
    inst_before_next  = inst_before;
    phase_before_next = phase_before;
    unique case (in_mode)
      MODE_ADVANCE: begin
        avg_before_next   = avg_now;
        inst_before_next  = inst_now;
        phase_before_next = phase_now;
        avg_next          = avg_c;
        inst_next         = inst_s[24:0];
        phase_next        = ph_s;
      end
      MODE_REVERT: begin
        avg_next   = avg_before;
        inst_next  = inst_before;
        phase_next = phase_before;
      end
      MODE_LOAD: begin
        avg_next          = cfg.nom_used;
        inst_next         = 25'(cfg.nom_used);
        phase_next        = in_pload;
        avg_before_next   = cfg.nom_used;
        inst_before_next  = 25'(cfg.nom_used);
        phase_before_next = in_pload;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_now      <= RST_AVG;
      inst_now     <= 25'(RST_AVG);
      phase_now    <= '0;
      avg_before   <= RST_AVG;
      inst_before  <= 25'(RST_AVG);
      phase_before <= '0;
    end else if (take) begin
      avg_now      <= avg_next;
      inst_now     <= inst_next;
      phase_now    <= phase_next;
      avg_before   <= avg_before_next;
      inst_before  <= inst_before_next;
      phase_before <= phase_before_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_avg   <= avg_next;
      out_inst  <= inst_next;
      out_phase <= phase_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_revert_restores: assert property (@(posedge clk) disable iff (rst)
    take && in_mode == MODE_REVERT |=>
      avg_now == $past(avg_before) && phase_now == $past(phase_before))
    else $error("revert did not restore saved state");

  a_load_syncs_saved: assert property (@(posedge clk) disable iff (rst)
    take && in_mode == MODE_LOAD |=>
      avg_now == avg_before && inst_now == inst_before && phase_now == phase_before)
    else $error("load left saved state unequal");

  a_advance_saves: assert property (@(posedge clk) disable iff (rst)
    take && in_mode == MODE_ADVANCE |=>
      avg_before == $past(avg_now) && phase_before == $past(phase_now))
    else $error("advance did not save previous state");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    $past(take) |-> out_avg == avg_now && out_phase == phase_now)
    else $error("result word differs from updated state");
`endif

endmodule

// ===== rtl/clock_tracking_pi_loop.sv =====
`timescale 1ns / 1ps

// Symbol clock tracking PI loop. Each input word (tuser selects advance, revert or
// load) yields one result word with the average period, instantaneous period and
// wrapped phase after the step. A new word is accepted every cycle while the output
// is not stalled; the result passes through the input register, the registered
// gain products and the state/result register. The state loop (period add, phase
// add, two wrap passes, clamp) is combinational around the state register, which
// allows one word per clock. Write the APB registers only while no word is in flight.
module clock_tracking_pi_loop #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // timing_error[17:0], phase_load[42:18], zero fill
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // avg_period[23:0], inst_period[48:24],
                                 // clock_phase[73:49], zero fill
);
  import ctpl_pkg::*;

  localparam int GM_W = 44 - (FRAC_BITS + 4);

  cfg_t                  cfg;
  logic                  g_valid;
  logic                  g_ready;
  logic [1:0]            g_mode;
  logic signed [24:0]    g_pload;
  logic signed [GM_W-1:0] g_pb;
  logic signed [GM_W:0]  g_pab;
  logic [23:0]           r_avg;
  logic signed [24:0]    r_inst;
  logic signed [24:0]    r_phase;

  ctpl_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctpl_gain #(.FRAC_BITS(FRAC_BITS)) u_gain (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_err    (s_tdata[17:0]),
    .in_pload  (s_tdata[42:18]),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_mode  (g_mode),
    .out_pload (g_pload),
    .out_pb    (g_pb),
    .out_pab   (g_pab)
  );

  ctpl_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_mode   (g_mode),
    .in_pload  (g_pload),
    .in_pb     (g_pb),
    .in_pab    (g_pab),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_avg   (r_avg),
    .out_inst  (r_inst),
    .out_phase (r_phase)
  );

  assign m_tdata = {6'd0, r_phase, r_inst, r_avg};

endmodule

// ===== sim/clock_tracking_pi_loop_tb.sv =====
`timescale 1ns / 1ps

module clock_tracking_pi_loop_tb;
  import ctpl_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEG_WORDS   = 194;
  localparam int SEG_COUNT   = 8;

  // one result word, avg_period in the low bits as on m_tdata
  typedef struct packed {
    logic signed [24:0] phase;
    logic signed [24:0] inst;
    logic [23:0]        avg;
  } loop_out_t;

  typedef struct {
    bit                 is_reg;
    logic [2:0]         reg_idx;
    int                 reg_val;
    logic [1:0]         mode;
    logic signed [17:0] err;
    logic signed [24:0] pload;
    bit                 known;
    loop_out_t          res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // timing_error[17:0], phase_load[42:18], zero fill
  logic [1:0]  s_tuser = '0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // avg_period[23:0], inst_period[48:24],
                               // clock_phase[73:49], zero fill

  // register copy and loop state of the predictor
  logic signed [24:0] cfg_alpha = '0;
  logic signed [24:0] cfg_beta = '0;
  logic [23:0]        cfg_max = 24'd196608;
  logic [23:0]        cfg_min = 24'd65536;
  logic [23:0]        cfg_nom = 24'd131072;
  logic [23:0]        avg_now, avg_prev;
  logic signed [24:0] inst_now, inst_prev, phase_now, phase_prev;

  loop_out_t result_q[$];
  plan_row_t plan_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int words_checked = 0;
  int random_words = 0;
  int cycles = 0;

  clock_tracking_pi_loop u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat_s25(input longint x);
    if (x > 64'sd16777215) return 64'sd16777215;
    if (x < -64'sd16777216) return -64'sd16777216;
    return x;
  endfunction

  // gain * error back to FRAC_BITS, round half up
  function automatic longint gain_term(input logic signed [24:0] g,
                                       input logic signed [17:0] e);
    longint p;
    p = longint'(g) * longint'(e) + (longint'(1) << 19);
    return p >>> 20;
  endfunction

  function automatic logic [23:0] load_period();
    longint s;
    if (cfg_nom < cfg_min || cfg_nom > cfg_max) begin
      s = longint'(cfg_min) + longint'(cfg_max);
      return s[24:1];
    end
    return cfg_nom;
  endfunction

  function automatic loop_out_t loop_step(input logic [1:0] mode,
                                          input logic signed [17:0] err,
                                          input logic signed [24:0] pload);
    longint avg, inst, ph, mx, mn;
    loop_out_t r;
    mx = cfg_max;
    mn = cfg_min;
    case (mode)
      MODE_ADVANCE: begin
        avg_prev = avg_now;
        inst_prev = inst_now;
        phase_prev = phase_now;
        avg = longint'(avg_now) + gain_term(cfg_beta, err);
        inst = sat_s25(avg + gain_term(cfg_alpha, err));
        inst_now = inst[24:0];
        ph = longint'(phase_now) + inst;
        // wrap against the unclamped average, two passes
        for (int k = 0; k < 2; k++) begin
          if (2 * ph > avg) ph = ph - avg;
          else if (2 * ph <= -avg) ph = ph + avg;
        end
        ph = sat_s25(ph);
        phase_now = ph[24:0];
        if (avg > mx) avg = mx;
        else if (avg < mn) avg = mn;
        avg_now = avg[23:0];
      end
      MODE_REVERT: begin
        avg_now = avg_prev;
        inst_now = inst_prev;
        phase_now = phase_prev;
      end
      MODE_LOAD: begin
        avg_now = load_period();
        avg_prev = avg_now;
        inst_now = {1'b0, avg_now};
        inst_prev = inst_now;
        phase_now = pload;
        phase_prev = pload;
      end
      default: ;
    endcase
    r.avg = avg_now;
    r.inst = inst_now;
    r.phase = phase_now;
    return r;
  endfunction

  task automatic add_word(input logic [1:0] mode, input int err, input int pload);
    plan_row_t row;
    row = '{default: '0};
    row.mode = mode;
    row.err = 18'(err);
    row.pload = 25'(pload);
    plan_q.push_back(row);
  endtask

  task automatic add_known(input logic [1:0] mode, input int err, input int pload,
                           input int avg, input int inst, input int phase);
    plan_row_t row;
    row = '{default: '0};
    row.mode = mode;
    row.err = 18'(err);
    row.pload = 25'(pload);
    row.known = 1'b1;
    row.res.avg = 24'(avg);
    row.res.inst = 25'(inst);
    row.res.phase = 25'(phase);
    plan_q.push_back(row);
  endtask

  task automatic add_reg(input logic [2:0] idx, input int value);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = value;
    plan_q.push_back(row);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN_ALPHA: cfg_alpha = value[24:0];
      REG_GAIN_BETA:  cfg_beta = value[24:0];
      REG_PERIOD_HI:  cfg_max = value[23:0];
      REG_PERIOD_LO:  cfg_min = value[23:0];
      REG_NOM_PERIOD: cfg_nom = value[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input int alpha, input int beta, input int mx, input int mn,
                           input int nom);
    write_reg(REG_GAIN_ALPHA, alpha);
    write_reg(REG_GAIN_BETA, beta);
    write_reg(REG_PERIOD_HI, mx);
    write_reg(REG_PERIOD_LO, mn);
    write_reg(REG_NOM_PERIOD, nom);
  endtask

  task automatic send_word(input logic [1:0] mode, input logic signed [17:0] err,
                           input logic signed [24:0] pload, input bit known,
                           input loop_out_t known_res);
    loop_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {5'b0, pload, err};
    do @(posedge clk); while (!s_tready);
    pred = loop_step(mode, err, pload);
    result_q.push_back(known ? known_res : pred);
  endtask

  // drop valid and let every word in flight come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    loop_out_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[73:0];
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: avg %0d inst %0d phase %0d",
                   got.avg, got.inst, got.phase);
      end else begin
        want = result_q.pop_front();
        words_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: avg exp %0d got %0d, inst exp %0d got %0d, phase exp %0d got %0d",
                     words_checked, want.avg, got.avg, want.inst, got.inst,
                     want.phase, got.phase);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, result_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int r, e_i, p_i, alpha, beta, mx, mn, nom;
    logic [1:0] mode;
    logic signed [17:0] err;
    logic signed [24:0] pload, g25;
    loop_out_t none;

    none = '0;
    avg_now = load_period();
    avg_prev = avg_now;
    inst_now = {1'b0, avg_now};
    inst_prev = inst_now;
    phase_now = '0;
    phase_prev = '0;

    // reset state, gains zero: advances from phase zero land back on phase zero
    add_known(MODE_ADVANCE, 0, 0, 131072, 131072, 0);
    add_known(MODE_ADVANCE, 131071, 0, 131072, 131072, 0);
    add_known(MODE_ADVANCE, -131072, -1, 131072, 131072, 0);
    add_known(MODE_LOAD, 0, 16777215, 131072, 131072, 16777215);
    add_known(MODE_SPARE, 77, 3, 131072, 131072, 16777215);
    add_known(MODE_REVERT, 0, 0, 131072, 131072, 16777215);
    add_word(MODE_ADVANCE, 0, 0);
    add_word(MODE_REVERT, 0, 0);
    add_known(MODE_LOAD, 0, -16777216, 131072, 131072, -16777216);
    add_word(MODE_ADVANCE, -1, 0);
    // rounding ties of the gain product
    add_reg(REG_GAIN_ALPHA, 8);
    add_word(MODE_ADVANCE, 65536, 0);
    add_word(MODE_ADVANCE, -65536, 0);
    // average driven to exactly zero
    add_reg(REG_GAIN_ALPHA, 0);
    add_reg(REG_GAIN_BETA, 1 << 20);
    add_known(MODE_LOAD, 0, 0, 131072, 131072, 0);
    add_word(MODE_ADVANCE, -131072, 0);
    // extreme gains, average goes negative
    add_reg(REG_GAIN_ALPHA, 16777215);
    add_reg(REG_GAIN_BETA, -16777216);
    add_word(MODE_ADVANCE, 131071, 0);
    add_word(MODE_ADVANCE, -131072, 0);
    // min above max, nominal outside the range
    add_reg(REG_PERIOD_HI, 32'h10000);
    add_reg(REG_PERIOD_LO, 32'h30000);
    add_reg(REG_NOM_PERIOD, 32'h18000);
    add_known(MODE_LOAD, 0, 5, 32'h20000, 32'h20000, 5);
    add_word(MODE_ADVANCE, 100, 0);
    add_reg(REG_PERIOD_HI, 32'hFFFFFF);
    add_reg(REG_PERIOD_LO, 32'hFFFFFF);
    add_reg(REG_NOM_PERIOD, 32'hFFFFFF);
    add_known(MODE_LOAD, 0, 0, 16777215, 16777215, 0);
    add_word(MODE_ADVANCE, 131071, 0);
    add_word(MODE_ADVANCE, -131072, 0);
    add_reg(REG_PERIOD_HI, 0);
    add_reg(REG_PERIOD_LO, 0);
    add_reg(REG_NOM_PERIOD, 0);
    add_known(MODE_LOAD, 0, 0, 0, 0, 0);
    add_word(MODE_ADVANCE, 131071, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_reg) begin
        drain();
        write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
      end else begin
        send_word(plan_q[i].mode, plan_q[i].err, plan_q[i].pload, plan_q[i].known,
                  plan_q[i].res);
      end
    end

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      drain();
      case (seg)
        0: write_all(int'($urandom_range(1 << 17)) - (1 << 16),
                     int'($urandom_range(1 << 13)) - (1 << 12), 196608, 65536, 131072);
        1: write_all(16777215, -16777216, 32'hFFFFFF, 0, 32'hFFFFFF);
        2: write_all(-16777216, 16777215, 0, 0, 0);
        3: write_all(int'($urandom_range(1 << 17)) - (1 << 16),
                     int'($urandom_range(1 << 13)) - (1 << 12), 32'h10000, 32'h30000,
                     32'h18000);
        5: begin
          mn = $urandom_range(262144);
          mx = mn + int'($urandom_range(262144));
          nom = $urandom_range(524288);
          write_all(int'($urandom_range(1 << 18)) - (1 << 17),
                    int'($urandom_range(1 << 15)) - (1 << 14), mx, mn, nom);
        end
        7: write_all(0, 0, 196608, 65536, 131072);
        default: begin
          g25 = 25'($urandom());
          alpha = int'(g25);
          g25 = 25'($urandom());
          beta = int'(g25);
          write_all(alpha, beta, $urandom() & 32'hFFFFFF, $urandom() & 32'hFFFFFF,
                    $urandom() & 32'hFFFFFF);
        end
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // start each setting from a known load, then mostly advances
      send_word(MODE_LOAD, 0, 0, 1'b0, none);
      for (int n = 0; n < SEG_WORDS; n++) begin
        r = $urandom_range(99);
        if (r < 70) mode = MODE_ADVANCE;
        else if (r < 80) mode = MODE_REVERT;
        else if (r < 92) mode = MODE_LOAD;
        else mode = MODE_SPARE;
        r = $urandom_range(99);
        if (r < 50) e_i = int'($urandom_range(8191)) - 4096;
        else if (r < 85) e_i = $urandom();
        else begin
          case ($urandom_range(4))
            0: e_i = 131071;
            1: e_i = -131072;
            2: e_i = 0;
            3: e_i = 1;
            default: e_i = -1;
          endcase
        end
        err = 18'(e_i);
        if ($urandom_range(99) < 70) p_i = int'($urandom_range(262143)) - 131072;
        else p_i = $urandom();
        pload = 25'(p_i);
        send_word(mode, err, pload, 1'b0, none);
        random_words++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("%0d result words checked: directed table of %0d rows, %0d random words",
             words_checked, plan_q.size(), random_words);
    $display("settings spanned gain and period extremes, min above max, zero average");
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
